### src/rbmv_pkg.sv
// shared types and constants for the rectangular brush mask value unit
`timescale 1ns / 1ps

package rbmv_pkg;

   localparam int COORD_FRAC_BITS_DEF = 4;
   localparam int COEFF_FRAC_BITS_DEF = 22;

   localparam int ROT_BITS  = 14;
   localparam int WORK_BITS = 24;
   localparam int FADE_BITS = 16;
   localparam int SAT_EXP   = WORK_BITS + 16;
   localparam int CLAMP_EXP = 38;

   localparam int COORD_W   = 16;
   localparam int COEFF_W   = 24;
   localparam int ROT_W     = 16;
   localparam int VALUE_W   = 8;
   localparam int MAG_W     = 16;
   localparam int PROD_W    = 33;
   localparam int SUM_W     = 34;
   localparam int RMAG_W    = 32;
   localparam int RXA_W     = 33;
   localparam int NX_W      = 56;
   localparam int FX_W      = 57;
   localparam int N24_W     = WORK_BITS + 1;
   localparam int F24_W     = CLAMP_EXP + 1;
   localparam int NUM_W     = N24_W + F24_W + 2;
   localparam int DEN_W     = F24_W + 1;
   localparam int NMAG_W    = 63;
   localparam int DMAG_W    = F24_W;
   localparam int QUOT_BITS = WORK_BITS + 1;
   localparam int QBIT_W    = $clog2(QUOT_BITS);
   localparam int RET_W     = QUOT_BITS + 1;
   localparam int SCALED_W  = RET_W + VALUE_W;

   localparam int FRONT_STAGES = 5;
   localparam int INFLIGHT_W   = $clog2(FRONT_STAGES + 1);
   localparam int QUEUE_DEPTH  = 8;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;
   localparam int LATENCY      = FRONT_STAGES + 1 + 3 + QUOT_BITS + 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_NORM_X,
      REG_NORM_Y,
      REG_FADE_X,
      REG_FADE_Y,
      REG_ROT_COS,
      REG_ROT_SIN,
      REG_ANTIALIAS,
      REG_MASK_EMPTY
   } reg_idx_type;

   typedef struct packed {
      logic [COEFF_W-1:0]       norm_coeff_x;
      logic [COEFF_W-1:0]       norm_coeff_y;
      logic [COEFF_W-1:0]       fade_coeff_x;
      logic [COEFF_W-1:0]       fade_coeff_y;
      logic signed [ROT_W-1:0]  rotation_cos;
      logic signed [ROT_W-1:0]  rotation_sin;
      logic                     antialias_enable;
      logic                     mask_empty;
   } cfg_type;

   typedef struct packed {
      logic               force_full;
      logic               fade_gt_x;
      logic               fade_gt_y;
      logic [N24_W-1:0]   n24_x;
      logic [N24_W-1:0]   n24_y;
      logic [F24_W-1:0]   f24_x;
      logic [F24_W-1:0]   f24_y;
   } item_type;

endpackage

### src/rect_brush_mask_value_unit.sv
// top level of the rectangular brush mask value unit
`timescale 1ns / 1ps

// Gives the opacity of one pixel of a rotated rectangular brush tip with soft edges.
// Request channel: an offset word (req_offset_x, req_offset_y, signed Q11.4) is taken
// at a rising edge where start is high and busy is low.
// Response channel: rsp_mask_value is shown for one cycle with rsp_strobe high; the
// receiver takes it at the end of that cycle and cannot hold it off.
// One word per cycle is sustained. The path runs through the front pipeline
// (5 stages), one queue slot, and the back part, whose two fade ratio dividers
// produce one quotient bit per stage (25 stages) around 3 setup stages and 2
// output stages.
// busy rises only if the queue and front pipeline fill up together, which does not
// happen since the back part never stalls.
// Registers sit on an APB-style port at byte address 4*index; the user must write
// them only while the unit is idle, which the unit itself does not enforce.
// Reset clears the pipelines and queue and loads the register defaults.
module rect_brush_mask_value_unit #(
   parameter int COORD_FRAC_BITS = rbmv_pkg::COORD_FRAC_BITS_DEF,
   parameter int COEFF_FRAC_BITS = rbmv_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [rbmv_pkg::COORD_W-1:0]   req_offset_x,
   input  logic signed [rbmv_pkg::COORD_W-1:0]   req_offset_y,
   output logic                                  rsp_strobe,
   output logic [rbmv_pkg::VALUE_W-1:0]          rsp_mask_value,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rbmv_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [rbmv_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [rbmv_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import rbmv_pkg::*;

   cfg_type cfg_ff, cfg_in;
   reg_idx_type reg_idx;
   logic write_en;
   logic accept;
   logic push, pop;
   item_type push_item, pop_item;
   logic [INFLIGHT_W-1:0] inflight;
   logic [QUEUE_CNT_W-1:0] level;

   assign pready   = 1'b1;
   assign reg_idx  = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite && pready;
   assign busy     = (QUEUE_CNT_W'(inflight) + level) >= QUEUE_CNT_W'(QUEUE_DEPTH);
   assign accept   = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            REG_NORM_X:     cfg_in.norm_coeff_x     = pwdata[COEFF_W-1:0];
            REG_NORM_Y:     cfg_in.norm_coeff_y     = pwdata[COEFF_W-1:0];
            REG_FADE_X:     cfg_in.fade_coeff_x     = pwdata[COEFF_W-1:0];
            REG_FADE_Y:     cfg_in.fade_coeff_y     = pwdata[COEFF_W-1:0];
            REG_ROT_COS:    cfg_in.rotation_cos     = pwdata[ROT_W-1:0];
            REG_ROT_SIN:    cfg_in.rotation_sin     = pwdata[ROT_W-1:0];
            REG_ANTIALIAS:  cfg_in.antialias_enable = pwdata[0];
            REG_MASK_EMPTY: cfg_in.mask_empty       = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NORM_X:     prdata = CSR_DATA_W'(cfg_ff.norm_coeff_x);
         REG_NORM_Y:     prdata = CSR_DATA_W'(cfg_ff.norm_coeff_y);
         REG_FADE_X:     prdata = CSR_DATA_W'(cfg_ff.fade_coeff_x);
         REG_FADE_Y:     prdata = CSR_DATA_W'(cfg_ff.fade_coeff_y);
         REG_ROT_COS:    prdata = CSR_DATA_W'(unsigned'(cfg_ff.rotation_cos));
         REG_ROT_SIN:    prdata = CSR_DATA_W'(unsigned'(cfg_ff.rotation_sin));
         REG_ANTIALIAS:  prdata = CSR_DATA_W'(cfg_ff.antialias_enable);
         REG_MASK_EMPTY: prdata = CSR_DATA_W'(cfg_ff.mask_empty);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.norm_coeff_x     <= COEFF_W'(1) << COEFF_FRAC_BITS_DEF;
         cfg_ff.norm_coeff_y     <= COEFF_W'(1) << COEFF_FRAC_BITS_DEF;
         cfg_ff.fade_coeff_x     <= COEFF_W'(1) << FADE_BITS;
         cfg_ff.fade_coeff_y     <= COEFF_W'(1) << FADE_BITS;
         cfg_ff.rotation_cos     <= ROT_W'(1) << ROT_BITS;
         cfg_ff.rotation_sin     <= '0;
         cfg_ff.antialias_enable <= 1'b0;
         cfg_ff.mask_empty       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbmv_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .offset_x (req_offset_x),
      .offset_y (req_offset_y),
      .cfg      (cfg_ff),
      .push     (push),
      .item     (push_item),
      .inflight (inflight)
   );

   rbmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .level     (level)
   );

   rbmv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop),
      .in_item    (pop_item),
      .out_strobe (rsp_strobe),
      .out_value  (rsp_mask_value)
   );

endmodule

### src/rbmv_front.sv
// front part: rotation, normalization and classification of each offset word
`timescale 1ns / 1ps

module rbmv_front #(
   parameter int COORD_FRAC_BITS = rbmv_pkg::COORD_FRAC_BITS_DEF,
   parameter int COEFF_FRAC_BITS = rbmv_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [rbmv_pkg::COORD_W-1:0]   offset_x,
   input  logic signed [rbmv_pkg::COORD_W-1:0]   offset_y,
   input  rbmv_pkg::cfg_type                     cfg,
   output logic                                  push,
   output rbmv_pkg::item_type                    item,
   output logic [rbmv_pkg::INFLIGHT_W-1:0]       inflight
);
   import rbmv_pkg::*;

   localparam int FRAC      = COORD_FRAC_BITS + ROT_BITS;
   localparam int NORM_FRAC = FRAC + COEFF_FRAC_BITS;
   localparam int FADE_FRAC = FRAC + FADE_BITS;
   localparam int N_SHIFT   = NORM_FRAC - WORK_BITS;
   localparam int F_SHIFT   = FADE_FRAC - WORK_BITS;
   localparam logic [RXA_W-1:0] AA_ONE  = RXA_W'(1) << FRAC;
   localparam logic [NX_W-1:0]  NX_ONE  = NX_W'(1) << NORM_FRAC;
   localparam logic [FX_W-1:0]  FX_ONE  = FX_W'(1) << FADE_FRAC;
   localparam logic [FX_W-1:0]  F24_MAX = FX_W'(1) << CLAMP_EXP;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic [MAG_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [PROD_W-1:0] xc_ff, xc_in, ys_ff, ys_in, yc_ff, yc_in, xs_ff, xs_in;
   logic signed [SUM_W-1:0] sum_x, sum_y, neg_x, neg_y;
   logic [RMAG_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [NX_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [RXA_W-1:0] rxa_ff, rxa_in, rya_ff, rya_in;
   logic [FX_W-1:0] fx_ff, fx_in, fy_ff, fy_in, f24_raw_x, f24_raw_y;
   logic [N24_W-1:0] n24x_ff, n24x_in, n24y_ff, n24y_in;
   logic outside_ff, outside_in;
   logic signed [COORD_W-1:0] neg_ox, neg_oy;

   always_comb begin
      valid_in = {valid_ff[FRONT_STAGES-2:0], accept};
      neg_ox   = -offset_x;
      neg_oy   = -offset_y;
      ax_in    = offset_x[COORD_W-1] ? MAG_W'(neg_ox) : MAG_W'(offset_x);
      ay_in    = offset_y[COORD_W-1] ? MAG_W'(neg_oy) : MAG_W'(offset_y);

      xc_in = PROD_W'($signed({1'b0, ax_ff})) * PROD_W'(cfg.rotation_cos);
      ys_in = PROD_W'($signed({1'b0, ay_ff})) * PROD_W'(cfg.rotation_sin);
      yc_in = PROD_W'($signed({1'b0, ay_ff})) * PROD_W'(cfg.rotation_cos);
      xs_in = PROD_W'($signed({1'b0, ax_ff})) * PROD_W'(cfg.rotation_sin);

      sum_x = SUM_W'(xc_ff) + SUM_W'(ys_ff);
      sum_y = SUM_W'(yc_ff) - SUM_W'(xs_ff);
      neg_x = -sum_x;
      neg_y = -sum_y;
      rx_in = sum_x[SUM_W-1] ? neg_x[RMAG_W-1:0] : sum_x[RMAG_W-1:0];
      ry_in = sum_y[SUM_W-1] ? neg_y[RMAG_W-1:0] : sum_y[RMAG_W-1:0];

      nx_in  = NX_W'(rx_ff) * NX_W'(cfg.norm_coeff_x);
      ny_in  = NX_W'(ry_ff) * NX_W'(cfg.norm_coeff_y);
      rxa_in = RXA_W'(rx_ff) + (cfg.antialias_enable ? AA_ONE : '0);
      rya_in = RXA_W'(ry_ff) + (cfg.antialias_enable ? AA_ONE : '0);

      fx_in      = FX_W'(rxa_ff) * FX_W'(cfg.fade_coeff_x);
      fy_in      = FX_W'(rya_ff) * FX_W'(cfg.fade_coeff_y);
      outside_in = (nx_ff > NX_ONE) || (ny_ff > NX_ONE);
      n24x_in    = N24_W'(nx_ff >> N_SHIFT);
      n24y_in    = N24_W'(ny_ff >> N_SHIFT);

      f24_raw_x       = fx_ff >> F_SHIFT;
      f24_raw_y       = fy_ff >> F_SHIFT;
      item.force_full = cfg.mask_empty || outside_ff;
      item.fade_gt_x  = fx_ff > FX_ONE;
      item.fade_gt_y  = fy_ff > FX_ONE;
      item.n24_x      = n24x_ff;
      item.n24_y      = n24y_ff;
      item.f24_x      = (f24_raw_x > F24_MAX) ? F24_W'(F24_MAX) : f24_raw_x[F24_W-1:0];
      item.f24_y      = (f24_raw_y > F24_MAX) ? F24_W'(F24_MAX) : f24_raw_y[F24_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      xc_ff      <= xc_in;
      ys_ff      <= ys_in;
      yc_ff      <= yc_in;
      xs_ff      <= xs_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      rxa_ff     <= rxa_in;
      rya_ff     <= rya_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      outside_ff <= outside_in;
      n24x_ff    <= n24x_in;
      n24y_ff    <= n24y_in;
   end

   assign push     = valid_ff[FRONT_STAGES-1];
   assign inflight = INFLIGHT_W'($countones(valid_ff));

endmodule

### src/rbmv_queue.sv
// short queue between the front and back parts
`timescale 1ns / 1ps

module rbmv_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  rbmv_pkg::item_type                 push_item,
   output logic                               pop,
   output rbmv_pkg::item_type                 pop_item,
   output logic [rbmv_pkg::QUEUE_CNT_W-1:0]   level
);
   import rbmv_pkg::*;

   item_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      pop       = count_ff != '0;
      pop_item  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign level = count_ff;

endmodule

### src/rbmv_back.sv
// back part: fade ratios through pipelined dividers, selection and scaling
`timescale 1ns / 1ps

module rbmv_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  rbmv_pkg::item_type                in_item,
   output logic                              out_strobe,
   output logic [rbmv_pkg::VALUE_W-1:0]      out_value
);
   import rbmv_pkg::*;

   localparam int DIV_LAST = QUOT_BITS;
   localparam logic signed [DEN_W-1:0] WORK_ONE = DEN_W'(1) << WORK_BITS;
   localparam logic [RET_W-1:0] RET_MAX = RET_W'(1) << QUOT_BITS;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef struct packed {
      logic               force_full;
      logic               fade_gt_x;
      logic               fade_gt_y;
   } side_type;

   typedef struct packed {
      logic [DMAG_W-1:0]    rem;
      logic [QUOT_BITS-1:0] low;
      logic [QUOT_BITS-1:0] quot;
      logic [DMAG_W-1:0]    dmag;
      logic                 zero_den;
      logic                 positive;
      logic                 over;
      logic                 ge_sat;
   } div_type;

   function automatic div_type div_step(input div_type s, input logic [QBIT_W-1:0] b);
      logic [DMAG_W:0] t;
      div_type r;
      r = s;
      t = {s.rem, s.low[b]};
      if (t >= {1'b0, s.dmag}) begin
         t         = t - {1'b0, s.dmag};
         r.quot[b] = 1'b1;
      end
      r.rem = t[DMAG_W-1:0];
      return r;
   endfunction

   logic [DIV_LAST+4:0] valid_ff, valid_in;
   side_type side_ff [DIV_LAST+4];

   logic signed [NUM_W-1:0] num_ff [2], num_in [2];
   logic signed [DEN_W-1:0] den_ff [2], den_in [2];
   logic [NMAG_W-1:0] nmag_ff [2], nmag_in [2];
   logic [DMAG_W-1:0] dmag_ff [2], dmag_in [2];
   logic zero_ff [2], zero_in [2], pos_ff [2], pos_in [2];
   div_type div_ff [2][DIV_LAST+1];
   div_type div_in [2][DIV_LAST+1];
   logic signed [NUM_W-1:0] num_neg [2];
   logic signed [DEN_W-1:0] den_neg [2], m_val [2];
   logic [N24_W-1:0] n24 [2];
   logic [F24_W-1:0] f24 [2];
   logic [RET_W-1:0] qc [2];
   logic ge [2];
   logic lt;
   logic [RET_W-1:0] ret_ff, ret_in;
   logic [SCALED_W-1:0] scaled;
   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = {valid_ff[DIV_LAST+3:0], in_valid};
      n24[0]   = in_item.n24_x;
      n24[1]   = in_item.n24_y;
      f24[0]   = in_item.f24_x;
      f24[1]   = in_item.f24_y;
      for (int t = 0; t < 2; t++) begin
         m_val[t]  = $signed({1'b0, f24[t]}) - WORK_ONE;
         num_in[t] = NUM_W'($signed({1'b0, n24[t]})) * NUM_W'(m_val[t]);
         den_in[t] = $signed({1'b0, f24[t]}) - $signed(DEN_W'(n24[t]));

         num_neg[t] = -num_ff[t];
         den_neg[t] = -den_ff[t];
         nmag_in[t] = num_ff[t][NUM_W-1] ? num_neg[t][NMAG_W-1:0] : num_ff[t][NMAG_W-1:0];
         dmag_in[t] = den_ff[t][DEN_W-1] ? den_neg[t][DMAG_W-1:0] : den_ff[t][DMAG_W-1:0];
         zero_in[t] = den_ff[t] == '0;
         pos_in[t]  = (num_ff[t] != '0) && (den_ff[t] != '0)
                      && (num_ff[t][NUM_W-1] == den_ff[t][DEN_W-1]);

         div_in[t][0].rem      = DMAG_W'(nmag_ff[t][NMAG_W-1:QUOT_BITS]);
         div_in[t][0].low      = nmag_ff[t][QUOT_BITS-1:0];
         div_in[t][0].quot     = '0;
         div_in[t][0].dmag     = dmag_ff[t];
         div_in[t][0].zero_den = zero_ff[t];
         div_in[t][0].positive = pos_ff[t];
         div_in[t][0].over     = {1'b0, nmag_ff[t]} >= {dmag_ff[t], {QUOT_BITS{1'b0}}};
         div_in[t][0].ge_sat   = pos_ff[t]
                                 && (dmag_ff[t][DMAG_W-1:NMAG_W-SAT_EXP] == '0)
                                 && (nmag_ff[t] >= {dmag_ff[t][NMAG_W-SAT_EXP-1:0],
                                                    {SAT_EXP{1'b0}}});
         for (int k = 0; k < DIV_LAST; k++) begin
            div_in[t][k+1] = div_step(div_ff[t][k], QBIT_W'(QUOT_BITS - 1 - k));
         end

         if (div_ff[t][DIV_LAST].zero_den) begin
            qc[t] = RET_MAX;
            ge[t] = 1'b1;
         end else if (!div_ff[t][DIV_LAST].positive) begin
            qc[t] = '0;
            ge[t] = 1'b0;
         end else if (div_ff[t][DIV_LAST].over) begin
            qc[t] = RET_MAX;
            ge[t] = div_ff[t][DIV_LAST].ge_sat;
         end else begin
            qc[t] = RET_W'(div_ff[t][DIV_LAST].quot);
            ge[t] = 1'b0;
         end
      end

      lt = ge[1] ? !ge[0] : (!ge[0] && (qc[0] < qc[1]));
      if (lt && side_ff[DIV_LAST+2].fade_gt_y) begin
         ret_in = qc[1];
      end else if (side_ff[DIV_LAST+2].fade_gt_x) begin
         ret_in = qc[0];
      end else begin
         ret_in = '0;
      end

      scaled = (SCALED_W'(ret_ff) << VALUE_W) - SCALED_W'(ret_ff);
      if (side_ff[DIV_LAST+3].force_full) begin
         value_in = VALUE_MAX;
      end else if ((scaled >> WORK_BITS) > SCALED_W'(VALUE_MAX)) begin
         value_in = VALUE_MAX;
      end else begin
         value_in = VALUE_W'(scaled >> WORK_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{force_full: in_item.force_full, fade_gt_x: in_item.fade_gt_x,
                      fade_gt_y: in_item.fade_gt_y};
      for (int s = 1; s < DIV_LAST + 4; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      for (int t = 0; t < 2; t++) begin
         num_ff[t]  <= num_in[t];
         den_ff[t]  <= den_in[t];
         nmag_ff[t] <= nmag_in[t];
         dmag_ff[t] <= dmag_in[t];
         zero_ff[t] <= zero_in[t];
         pos_ff[t]  <= pos_in[t];
         for (int k = 0; k <= DIV_LAST; k++) begin
            div_ff[t][k] <= div_in[t][k];
         end
      end
      ret_ff   <= ret_in;
      value_ff <= value_in;
   end

   assign out_strobe = valid_ff[DIV_LAST+4];
   assign out_value  = value_ff;

endmodule

### src/rbmv_checker.sv
// port-level checks for the rectangular brush mask value unit, bound to the top level
`timescale 1ns / 1ps

module rbmv_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   import rbmv_pkg::*;

   a_reset_clears_strobe: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe high right after reset");

   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted word gave no result after fixed latency");

   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted word");

endmodule

bind rect_brush_mask_value_unit rbmv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
